// ===== rtl/dq_pkg.sv =====
// shared types and constants for the double-ended queue
package dq_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int ID_W          = 32;
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 2;

    // operation codes of an input transfer
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_DUMP       = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4
    } op_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_ENTRY = 2'd3
    } status_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_POP,
        BK_DUMP
    } back_state_t;

    // one classified command between front and back
    typedef struct packed {
        op_t                   op;
        logic signed [ID_W-1:0] id;
    } cmd_t;

endpackage

// ===== rtl/double_ended_queue.sv =====
// top level: bounded double-ended queue of record identifiers
// a push result passes the holding stage, the command queue and the result register; a pop
// result also waits in the pop state for the ring read; pushes sustain one transfer a cycle
// unless the result side stalls; a dump gives one result per entry via the single read port
// reset clears pointers, count and all valids; the ring contents are left as they are
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [dq_pkg::OP_W-1:0]        op,
    input  logic signed [dq_pkg::ID_W-1:0] entry_id,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [dq_pkg::STATUS_W-1:0]    status,
    output logic signed [dq_pkg::ID_W-1:0] out_id,
    output logic                           is_last
);

    logic         cmd_push;
    dq_pkg::cmd_t cmd_in;
    logic         cmd_full;
    logic         cmd_pop;
    dq_pkg::cmd_t cmd_out;
    logic         cmd_valid;

    // decode and hold incoming transfers
    dq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .entry_id (entry_id),
        .cmd_push (cmd_push),
        .cmd_data (cmd_in),
        .cmd_full (cmd_full)
    );

    // decoupling queue
    dq_cmd_fifo u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .not_empty (cmd_valid)
    );

    // ring buffer execution
    dq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_data  (cmd_out),
        .cmd_pop   (cmd_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .out_id    (out_id),
        .is_last   (is_last)
    );

endmodule

// ===== rtl/dq_front.sv =====
// front end: accepts input transfers, drops unknown codes, queues commands
module dq_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [dq_pkg::OP_W-1:0]       op,
    input  logic signed [dq_pkg::ID_W-1:0] entry_id,
    output logic                          cmd_push,
    output dq_pkg::cmd_t                  cmd_data,
    input  logic                          cmd_full
);

    logic         hold_valid_reg;
    logic         hold_valid_next;
    dq_pkg::cmd_t hold_cmd_reg;
    logic         known_op;
    logic         in_take;

    // classify the operation code
    always_comb
    begin
        unique case (op)
            dq_pkg::OP_PUSH_FRONT,
            dq_pkg::OP_PUSH_BACK,
            dq_pkg::OP_DUMP,
            dq_pkg::OP_POP_FRONT,
            dq_pkg::OP_POP_BACK: known_op = 1'b1;
            default:             known_op = 1'b0;
        endcase
    end

    // holding stage hands on to the command queue
    assign cmd_push = hold_valid_reg && !cmd_full;
    assign cmd_data = hold_cmd_reg;
    assign in_stall = hold_valid_reg && cmd_full;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (cmd_push)
        begin
            hold_valid_next = 1'b0;
        end
        if (in_take && known_op)
        begin
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // command payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take && known_op)
        begin
            hold_cmd_reg.op <= dq_pkg::op_t'(op);
            hold_cmd_reg.id <= entry_id;
        end
    end

endmodule

// ===== rtl/dq_cmd_fifo.sv =====
// two-entry command queue between front and back
module dq_cmd_fifo (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  dq_pkg::cmd_t push_data,
    output logic         full,
    input  logic         pop,
    output dq_pkg::cmd_t pop_data,
    output logic         not_empty
);

    dq_pkg::cmd_t slot_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   fill_reg;
    logic [1:0]   fill_next;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/dq_back.sv =====
// back end: ring buffer, pointer control and result register
module dq_back #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    input  dq_pkg::cmd_t                       cmd_data,
    output logic                               cmd_pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [dq_pkg::STATUS_W-1:0]        status,
    output logic signed [dq_pkg::ID_W-1:0]     out_id,
    output logic                               is_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_COUNT  = CW'(1);

    logic [dq_pkg::ID_W-1:0] mem [DEPTH];

    dq_pkg::back_state_t state_reg, state_next;
    logic [AW-1:0] front_reg, front_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] remain_reg, remain_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [dq_pkg::ID_W-1:0] rd_data_reg;

    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [dq_pkg::ID_W-1:0] wr_data;

    logic                        out_valid_reg, out_valid_next;
    dq_pkg::status_t             out_status_reg;
    logic [dq_pkg::ID_W-1:0]     out_id_reg;
    logic                        out_last_reg;

    logic                    res_load;
    dq_pkg::status_t         res_status;
    logic [dq_pkg::ID_W-1:0] res_id;
    logic                    res_last;

    logic          out_free;
    logic          q_full;
    logic          q_empty;
    logic [AW-1:0] front_dec;
    logic [AW-1:0] front_inc;
    logic [AW-1:0] tail_dec;
    logic [AW-1:0] tail_inc;
    logic [AW-1:0] rd_inc;

    assign out_free = !out_valid_reg || !out_stall;
    assign q_full   = (count_reg == FULL_COUNT);
    assign q_empty  = (count_reg == '0);

    // ring pointer steps with wrap at the depth
    assign front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - AW'(1);
    assign front_inc = (front_reg == LAST_SLOT) ? '0 : front_reg + AW'(1);
    assign tail_dec  = (tail_reg == '0) ? LAST_SLOT : tail_reg - AW'(1);
    assign tail_inc  = (tail_reg == LAST_SLOT) ? '0 : tail_reg + AW'(1);
    assign rd_inc    = (rd_addr_reg == LAST_SLOT) ? '0 : rd_addr_reg + AW'(1);

    // sequencer: next state, pointer updates and result load
    always_comb
    begin
        state_next   = state_reg;
        front_next   = front_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        remain_next  = remain_reg;
        rd_addr_next = rd_addr_reg;
        cmd_pop      = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = tail_reg;
        wr_data      = cmd_data.id;
        res_load     = 1'b0;
        res_status   = dq_pkg::STATUS_DONE;
        res_id       = '0;
        res_last     = 1'b1;

        unique case (state_reg)
            dq_pkg::BK_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd_data.op)
                        dq_pkg::OP_PUSH_FRONT:
                        begin
                            res_load = 1'b1;
                            if (q_full)
                            begin
                                res_status = dq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = front_dec;
                                front_next = front_dec;
                                count_next = count_reg + ONE_COUNT;
                            end
                        end
                        dq_pkg::OP_PUSH_BACK:
                        begin
                            res_load = 1'b1;
                            if (q_full)
                            begin
                                res_status = dq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = tail_reg;
                                tail_next  = tail_inc;
                                count_next = count_reg + ONE_COUNT;
                            end
                        end
                        dq_pkg::OP_POP_FRONT:
                        begin
                            if (q_empty)
                            begin
                                res_load   = 1'b1;
                                res_status = dq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                rd_addr_next = front_reg;
                                front_next   = front_inc;
                                count_next   = count_reg - ONE_COUNT;
                                state_next   = dq_pkg::BK_POP;
                            end
                        end
                        dq_pkg::OP_POP_BACK:
                        begin
                            if (q_empty)
                            begin
                                res_load   = 1'b1;
                                res_status = dq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                rd_addr_next = tail_dec;
                                tail_next    = tail_dec;
                                count_next   = count_reg - ONE_COUNT;
                                state_next   = dq_pkg::BK_POP;
                            end
                        end
                        dq_pkg::OP_DUMP:
                        begin
                            if (q_empty)
                            begin
                                res_load   = 1'b1;
                                res_status = dq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                rd_addr_next = front_reg;
                                remain_next  = count_reg;
                                state_next   = dq_pkg::BK_DUMP;
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            // popped slot's registered read data is taken here
            dq_pkg::BK_POP:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    res_status = dq_pkg::STATUS_DONE;
                    res_id     = rd_data_reg;
                    state_next = dq_pkg::BK_IDLE;
                end
            end
            // walk front to back, an entry a cycle unless stalled
            dq_pkg::BK_DUMP:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    res_status = dq_pkg::STATUS_ENTRY;
                    res_id     = rd_data_reg;
                    res_last   = (remain_reg == ONE_COUNT);
                    if (remain_reg == ONE_COUNT)
                    begin
                        state_next = dq_pkg::BK_IDLE;
                    end
                    else
                    begin
                        remain_next  = remain_reg - ONE_COUNT;
                        rd_addr_next = rd_inc;
                    end
                end
            end
            default:
            begin
                state_next = dq_pkg::BK_IDLE;
            end
        endcase
    end

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dq_pkg::BK_IDLE;
            front_reg     <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            remain_reg    <= '0;
            rd_addr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            rd_addr_reg   <= rd_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_status_reg <= res_status;
            out_id_reg     <= res_id;
            out_last_reg   <= res_last;
        end
    end

    // ring buffer storage with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr_next];
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign out_id    = $signed(out_id_reg);
    assign is_last   = out_last_reg;

endmodule

// ===== bench/tb.sv =====
// testbench for the double-ended queue: directed and random operations against a ring predictor
`timescale 1ns / 100ps

module tb;

    localparam int          RING_DEPTH   = 64;
    localparam int unsigned REPORT_LIMIT = 10;
    localparam int unsigned DRAIN_CYCLES = 32;
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    // codes outside the operation set, which the block ignores
    localparam logic [dq_pkg::OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [dq_pkg::OP_W-1:0] OP_RESERVED_LAST  = 3'd7;

    localparam logic signed [dq_pkg::ID_W-1:0] ID_MIN  = 32'sh8000_0000;
    localparam logic signed [dq_pkg::ID_W-1:0] ID_MAX  = 32'sh7fff_ffff;
    localparam logic signed [dq_pkg::ID_W-1:0] ID_ONES = 32'shffff_ffff;
    localparam logic signed [dq_pkg::ID_W-1:0] ID_ODD  = 32'sh5555_5555;
    localparam logic signed [dq_pkg::ID_W-1:0] ID_EVEN = 32'shaaaa_aaaa;

    typedef struct {
        dq_pkg::status_t                status;
        logic signed [dq_pkg::ID_W-1:0] id;
        logic                           last;
    } queue_answer_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    logic [dq_pkg::OP_W-1:0]         op        = '0;
    logic signed [dq_pkg::ID_W-1:0]  entry_id  = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [dq_pkg::STATUS_W-1:0]     status;
    logic signed [dq_pkg::ID_W-1:0]  out_id;
    logic                            is_last;

    // predictor state: copy of the ring, its front slot and its fill level
    logic signed [dq_pkg::ID_W-1:0]  ring_copy [RING_DEPTH];
    int                              head_slot  = 0;
    int                              fill_count = 0;
    queue_answer_t                   answers_due [$];

    int unsigned             mismatch_count = 0;
    int unsigned             cycle_count    = 0;
    int unsigned             sender_idle_pct = 0;
    int unsigned             recv_stall_pct  = 0;

    double_ended_queue #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .entry_id (entry_id),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status   (status),
        .out_id   (out_id),
        .is_last  (is_last)
    );

    always #4 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // queue one answer with the given status and identifier
    task automatic add_answer(input dq_pkg::status_t st,
                              input logic signed [dq_pkg::ID_W-1:0] id,
                              input logic last);
        queue_answer_t a;
        a.status = st;
        a.id     = id;
        a.last   = last;
        answers_due.push_back(a);
    endtask

    // update the ring copy for one accepted operation and queue what it should give
    task automatic predict_queue_op(input logic [dq_pkg::OP_W-1:0] code,
                                    input logic signed [dq_pkg::ID_W-1:0] id);
        int k;
        case (code)
            dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK:
            begin
                if (fill_count >= RING_DEPTH)
                    add_answer(dq_pkg::STATUS_FULL, '0, 1'b1);
                else
                begin
                    if (code == dq_pkg::OP_PUSH_FRONT)
                    begin
                        head_slot = (head_slot + RING_DEPTH - 1) % RING_DEPTH;
                        ring_copy[head_slot] = id;
                    end
                    else
                        ring_copy[(head_slot + fill_count) % RING_DEPTH] = id;
                    fill_count++;
                    add_answer(dq_pkg::STATUS_DONE, '0, 1'b1);
                end
            end
            dq_pkg::OP_DUMP:
            begin
                if (fill_count == 0)
                    add_answer(dq_pkg::STATUS_EMPTY, '0, 1'b1);
                else
                    for (k = 0; k < fill_count; k++)
                        add_answer(dq_pkg::STATUS_ENTRY,
                                   ring_copy[(head_slot + k) % RING_DEPTH],
                                   k == fill_count - 1);
            end
            dq_pkg::OP_POP_FRONT:
            begin
                if (fill_count == 0)
                    add_answer(dq_pkg::STATUS_EMPTY, '0, 1'b1);
                else
                begin
                    add_answer(dq_pkg::STATUS_DONE, ring_copy[head_slot], 1'b1);
                    head_slot = (head_slot + 1) % RING_DEPTH;
                    fill_count--;
                end
            end
            dq_pkg::OP_POP_BACK:
            begin
                if (fill_count == 0)
                    add_answer(dq_pkg::STATUS_EMPTY, '0, 1'b1);
                else
                begin
                    add_answer(dq_pkg::STATUS_DONE,
                               ring_copy[(head_slot + fill_count - 1) % RING_DEPTH], 1'b1);
                    fill_count--;
                end
            end
            default:
            begin
                // reserved codes leave the queue alone and give nothing
            end
        endcase
    endtask

    // drive one operation and wait for its transfer
    task automatic send_op(input logic [dq_pkg::OP_W-1:0] code,
                           input logic signed [dq_pkg::ID_W-1:0] id);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= code;
        entry_id <= id;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_queue_op(code, id);
    endtask

    // identifier with a bias towards the extremes
    function automatic logic signed [dq_pkg::ID_W-1:0] pick_id();
        case ($urandom_range(15))
            0:       return ID_MIN;
            1:       return ID_MAX;
            2:       return ID_ONES;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // compare one result transfer with the oldest answer due
    task automatic check_result();
        queue_answer_t want;
        if (answers_due.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected result: status %0d id %h last %b", status, out_id, is_last);
        end
        else
        begin
            want = answers_due.pop_front();
            if (status !== want.status || out_id !== want.id || is_last !== want.last)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("mismatch: status %0d/%0d id %h/%h last %b/%b (expected/actual)",
                             want.status, status, want.id, out_id, want.last, is_last);
            end
        end
    endtask

    // result side: check each transfer, stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_result();
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // pops and dumps on an empty queue, reserved codes
    task automatic test_empty_queue();
        logic [dq_pkg::OP_W-1:0] code;
        send_op(dq_pkg::OP_DUMP, '0);
        send_op(dq_pkg::OP_POP_FRONT, ID_ONES);
        send_op(dq_pkg::OP_POP_BACK, '0);
        for (code = OP_RESERVED_FIRST; code != OP_RESERVED_LAST; code++)
            send_op(code, pick_id());
        send_op(OP_RESERVED_LAST, ID_MAX);
        send_op(dq_pkg::OP_POP_BACK, '0);
    endtask

    // extreme identifiers through both ends, ring wrap below slot zero
    task automatic test_id_extremes();
        send_op(dq_pkg::OP_PUSH_FRONT, ID_MIN);
        send_op(dq_pkg::OP_PUSH_BACK, ID_MAX);
        send_op(dq_pkg::OP_PUSH_FRONT, ID_ONES);
        send_op(dq_pkg::OP_PUSH_BACK, '0);
        send_op(dq_pkg::OP_PUSH_FRONT, ID_ODD);
        send_op(dq_pkg::OP_PUSH_BACK, ID_EVEN);
        send_op(dq_pkg::OP_DUMP, '0);
        send_op(dq_pkg::OP_POP_FRONT, '0);
        send_op(dq_pkg::OP_POP_BACK, '0);
        send_op(dq_pkg::OP_POP_FRONT, '0);
        send_op(dq_pkg::OP_POP_BACK, '0);
        send_op(dq_pkg::OP_DUMP, '0);
        send_op(dq_pkg::OP_POP_FRONT, '0);
        send_op(dq_pkg::OP_POP_BACK, '0);
        send_op(dq_pkg::OP_POP_BACK, '0);
        send_op(dq_pkg::OP_DUMP, '0);
    endtask

    // fill to capacity, pushes on a full ring, full dump, then drain
    task automatic test_full_ring();
        while (fill_count < RING_DEPTH)
            send_op($urandom_range(1) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK,
                    pick_id());
        send_op(dq_pkg::OP_PUSH_FRONT, pick_id());
        send_op(dq_pkg::OP_PUSH_BACK, pick_id());
        send_op(dq_pkg::OP_DUMP, '0);
        while (fill_count > 0)
            send_op($urandom_range(1) ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_BACK,
                    pick_id());
        send_op(dq_pkg::OP_POP_FRONT, '0);
        send_op(dq_pkg::OP_DUMP, '0);
    endtask

    // bursts that lean towards growth, shrinkage or balance, with dumps and noise
    task automatic test_random_traffic(input int unsigned n_ops);
        int unsigned sent;
        int unsigned burst;
        int unsigned push_pct;
        int unsigned roll;
        sent = 0;
        while (sent < n_ops)
        begin
            burst    = $urandom_range(16, 4);
            push_pct = 20 + 30 * $urandom_range(2);
            repeat (burst)
            begin
                roll = $urandom_range(99);
                if (roll < 2)
                    send_op(dq_pkg::OP_W'($urandom_range(OP_RESERVED_LAST, OP_RESERVED_FIRST)),
                            pick_id());
                else
                begin
                    if (roll < 8)
                        send_op(dq_pkg::OP_DUMP, pick_id());
                    else if ($urandom_range(99) < push_pct)
                        send_op($urandom_range(1) ? dq_pkg::OP_PUSH_FRONT
                                                  : dq_pkg::OP_PUSH_BACK, pick_id());
                    else
                        send_op($urandom_range(1) ? dq_pkg::OP_POP_FRONT
                                                  : dq_pkg::OP_POP_BACK, pick_id());
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_queue();
        test_id_extremes();

        sender_idle_pct = 27;
        recv_stall_pct  = 27;
        test_full_ring();

        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        test_random_traffic(60);
        sender_idle_pct = 76;
        test_random_traffic(60);
        sender_idle_pct = 0;
        recv_stall_pct  = 76;
        test_random_traffic(60);
        sender_idle_pct = 27;
        recv_stall_pct  = 27;
        test_random_traffic(60);

        // let the last results drain
        in_valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && answers_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
